>>> rtl/bbc_pkg.sv
// shared types, constants and the reciprocal table of the edge-clipped 3x3 box blur
`default_nettype none

package bbc_pkg;

   localparam int PIX_W        = 24;
   localparam int ROW_W        = 12;
   localparam int WIDTH_CFG_W  = 11;
   localparam int HEIGHT_CFG_W = 13;
   localparam int MAX_HEIGHT   = 4096;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 13;
   localparam int CNT_W        = 4;
   localparam int SUM_W        = 12;
   localparam int NUM_W        = 13;
   localparam int RECIP_W      = 18;
   localparam int RECIP_SHIFT  = 18;
   localparam int PROD_W       = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_type;

   typedef struct packed {
      logic c_ge1;
      logic c_ge2;
      logic r_ge1;
      logic r_ge2;
      logic last_col;
      logic last_row;
   } pos_type;

   // ceil(2^18 / (2*count)), exact for every numerator the window can give
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
      logic [RECIP_W-1:0] r;
      case (cnt)
         4'd1:    r = 18'd131072;
         4'd2:    r = 18'd65536;
         4'd3:    r = 18'd43691;
         4'd4:    r = 18'd32768;
         4'd5:    r = 18'd26215;
         4'd6:    r = 18'd21846;
         4'd7:    r = 18'd18725;
         4'd8:    r = 18'd16384;
         4'd9:    r = 18'd14564;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/box_blur_3x3_edge_clipped_core.sv
// top level of the edge-clipped 3x3 box blur over a raster-order rgb stream
//
// req_* takes one rgb pixel per transaction in raster order; rsp_* returns
// blurred pixels in raster order, trailing the input by about one row.
// csr_* writes image_width (index 0) and image_height (index 1); write only
// while the block is idle. csr_ready is always high.
// each pixel enters a two-entry queue in the cycle it is accepted; the
// window engine then takes it from the queue, makes three line buffer
// reads and a drain step, and for each of its 0 to 4 results registers
// the sum, the reciprocal multiply and the output register; a closing
// select and three line buffer write steps follow, and only then is
// the next pixel taken. the single-port line buffer and the registered
// sum and multiply stages set this sequence.
// run_end marks the last result of a pixel, frame_end the bottom-right one.
// reset clears position counters, queue, engine and result valid flag and
// restores a 1024 x 1024 frame; line buffer contents are not cleared.
// when a result is held and rsp_ready is low, the result register holds and the engine waits,
// the queue still takes up to two more pixels before req_ready drops.
`default_nettype none

module box_blur_3x3_edge_clipped_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bbc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [bbc_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [7:0]                        req_red,
   input  wire logic [7:0]                        req_green,
   input  wire logic [7:0]                        req_blue,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [7:0]                             rsp_red_out,
   output logic [7:0]                             rsp_green_out,
   output logic [7:0]                             rsp_blue_out,
   output logic                                   rsp_run_end,
   output logic                                   rsp_frame_end
);
   import bbc_pkg::*;

   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int POS_W  = $bits(pos_type);
   localparam int DATA_W = PIX_W + POS_W + COL_W;

   logic              push_valid, push_ready, pop_valid, pop_ready;
   rgb_type           push_pix, pop_pix;
   pos_type           push_pos, pop_pos;
   logic [COL_W-1:0]  push_col, pop_col;
   logic [DATA_W-1:0] push_data, pop_data;

   bbc_front #(.MAX_WIDTH(MAX_WIDTH), .COL_W(COL_W)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_pix   (push_pix),
      .push_pos   (push_pos),
      .push_col   (push_col)
   );

   assign push_data = {push_col, push_pos, push_pix};

   bbc_queue #(.DATA_W(DATA_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_pix = pop_data[PIX_W-1:0];
   assign pop_pos = pop_data[PIX_W+POS_W-1:PIX_W];
   assign pop_col = pop_data[DATA_W-1:PIX_W+POS_W];

   bbc_back #(.MAX_WIDTH(MAX_WIDTH), .COL_W(COL_W)) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_pix       (pop_pix),
      .pop_pos       (pop_pos),
      .pop_col       (pop_col),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_run_end   (rsp_run_end),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire

>>> rtl/bbc_front.sv
// front end: size registers, pixel position tracking and classification
`default_nettype none

module bbc_front #(
   parameter int MAX_WIDTH = 1024,
   parameter int COL_W     = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bbc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [bbc_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [7:0]                        req_red,
   input  wire logic [7:0]                        req_green,
   input  wire logic [7:0]                        req_blue,
   output logic                                   push_valid,
   input  wire logic                              push_ready,
   output bbc_pkg::rgb_type                       push_pix,
   output bbc_pkg::pos_type                       push_pos,
   output logic [COL_W-1:0]                       push_col
);
   import bbc_pkg::*;

   logic [WIDTH_CFG_W-1:0]  width_ff;
   logic [HEIGHT_CFG_W-1:0] height_ff;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [COL_W-1:0]        last_col, c;
   logic [ROW_W-1:0]        last_row, r;
   logic                    is_last_col, is_last_row, accept;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_CFG_W'(1024);
         height_ff <= HEIGHT_CFG_W'(1024);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data[WIDTH_CFG_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0)
         last_col = '0;
      else if (32'(width_ff) > MAX_WIDTH)
         last_col = COL_W'(MAX_WIDTH - 1);
      else
         last_col = COL_W'(width_ff - WIDTH_CFG_W'(1));
      if (height_ff == '0)
         last_row = '0;
      else if (32'(height_ff) > MAX_HEIGHT)
         last_row = ROW_W'(MAX_HEIGHT - 1);
      else
         last_row = ROW_W'(height_ff - HEIGHT_CFG_W'(1));
   end

   // saturate a stale position after a size change
   assign c           = (col_ff > last_col) ? last_col : col_ff;
   assign r           = (row_ff > last_row) ? last_row : row_ff;
   assign is_last_col = (c == last_col);
   assign is_last_row = (r == last_row);

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && req_ready;

   assign push_pix.red       = req_red;
   assign push_pix.green     = req_green;
   assign push_pix.blue      = req_blue;
   assign push_pos.c_ge1     = (c != '0);
   assign push_pos.c_ge2     = (c > COL_W'(1));
   assign push_pos.r_ge1     = (r != '0);
   assign push_pos.r_ge2     = (r > ROW_W'(1));
   assign push_pos.last_col  = is_last_col;
   assign push_pos.last_row  = is_last_row;
   assign push_col           = c;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (is_last_col) begin
            col_in = '0;
            row_in = is_last_row ? '0 : r + ROW_W'(1);
         end else begin
            col_in = c + COL_W'(1);
            row_in = r;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/bbc_queue.sv
// two-entry queue between the front end and the window engine
`default_nettype none

module bbc_queue #(
   parameter int DATA_W = 40
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire logic [DATA_W-1:0] push_data,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output logic [DATA_W-1:0]      pop_data
);
   logic [DATA_W-1:0] entry_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = rd_ptr_ff ? entry_ff[1] : entry_ff[0];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         if (wr_ptr_ff) begin
            entry_ff[1] <= push_data;
         end else begin
            entry_ff[0] <= push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
   end

endmodule

`default_nettype wire

>>> rtl/bbc_back.sv
// window engine: line buffer access, clipped 3x3 means and result register
`default_nettype none

module bbc_back #(
   parameter int MAX_WIDTH = 1024,
   parameter int COL_W     = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   input  wire bbc_pkg::rgb_type  pop_pix,
   input  wire bbc_pkg::pos_type  pop_pos,
   input  wire logic [COL_W-1:0]  pop_col,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_red_out,
   output logic [7:0]             rsp_green_out,
   output logic [7:0]             rsp_blue_out,
   output logic                   rsp_run_end,
   output logic                   rsp_frame_end
);
   import bbc_pkg::*;

   localparam logic [1:0] KIND_ABOVE_LEFT = 2'd0;
   localparam logic [1:0] KIND_LAST_LEFT  = 2'd1;
   localparam logic [1:0] KIND_ABOVE_HERE = 2'd2;
   localparam logic [1:0] KIND_LAST_HERE  = 2'd3;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_READ   = 7'b0000010,
      ST_DRAIN  = 7'b0000100,
      ST_SELECT = 7'b0001000,
      ST_DIV    = 7'b0010000,
      ST_OUT    = 7'b0100000,
      ST_WRITE  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   rgb_type            pix_ff, recent0_ff, recent1_ff;
   pos_type            pos_ff;
   logic [COL_W-1:0]   col_ff;
   logic [1:0]         step_ff;
   logic [3:0]         pend_ff;
   rgb_type            old_win_ff [3];
   rgb_type            prv_win_ff [3];
   rgb_type            cur_win [3];
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_data_ff;
   logic               rd_pend_ff;
   logic [1:0]         rd_slot_ff;
   logic [COL_W-1:0]   mem_addr;
   logic               mem_we;
   logic [2*PIX_W-1:0] mem_wdata;
   logic [1:0]         kind_sel;
   logic [3:0]         kind_bit;
   logic [SUM_W-1:0]   sum_calc [3];
   logic [CNT_W-1:0]   cnt_calc;
   logic [SUM_W-1:0]   sum_ff [3];
   logic [CNT_W-1:0]   cnt_ff;
   logic [PROD_W-1:0]  prod_ff [3];
   logic               run_end_ff, frame_end_ff;
   logic               rsp_valid_ff, rsp_run_end_ff, rsp_frame_end_ff;
   logic [7:0]         rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic               out_load;
   logic [3:0]         new_mask;

   assign pop_ready = (state_ff == ST_IDLE);
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   assign cur_win[0] = recent1_ff;
   assign cur_win[1] = recent0_ff;
   assign cur_win[2] = pix_ff;

   assign new_mask[KIND_ABOVE_LEFT] = pop_pos.c_ge1 && pop_pos.r_ge1;
   assign new_mask[KIND_LAST_LEFT]  = pop_pos.c_ge1 && pop_pos.last_row;
   assign new_mask[KIND_ABOVE_HERE] = pop_pos.last_col && pop_pos.r_ge1;
   assign new_mask[KIND_LAST_HERE]  = pop_pos.last_col && pop_pos.last_row;

   always_comb begin
      if (pend_ff[KIND_ABOVE_LEFT])      kind_sel = KIND_ABOVE_LEFT;
      else if (pend_ff[KIND_LAST_LEFT])  kind_sel = KIND_LAST_LEFT;
      else if (pend_ff[KIND_ABOVE_HERE]) kind_sel = KIND_ABOVE_HERE;
      else                               kind_sel = KIND_LAST_HERE;
      kind_bit = 4'b0001 << kind_sel;
   end

   // clipped window sums for the selected output position
   always_comb begin
      logic [2:0] row_en;
      logic [2:0] col_en;
      rgb_type    px;
      for (int ch = 0; ch < 3; ch++) sum_calc[ch] = '0;
      cnt_calc  = '0;
      row_en[0] = (kind_sel == KIND_ABOVE_LEFT || kind_sel == KIND_ABOVE_HERE) && pos_ff.r_ge2;
      row_en[1] = pos_ff.r_ge1;
      row_en[2] = 1'b1;
      col_en[0] = (kind_sel == KIND_ABOVE_LEFT || kind_sel == KIND_LAST_LEFT) && pos_ff.c_ge2;
      col_en[1] = pos_ff.c_ge1;
      col_en[2] = 1'b1;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (i == 0)      px = old_win_ff[j];
            else if (i == 1) px = prv_win_ff[j];
            else             px = cur_win[j];
            if (row_en[i] && col_en[j]) begin
               sum_calc[0] = sum_calc[0] + SUM_W'(px.red);
               sum_calc[1] = sum_calc[1] + SUM_W'(px.green);
               sum_calc[2] = sum_calc[2] + SUM_W'(px.blue);
               cnt_calc    = cnt_calc + CNT_W'(1);
            end
         end
      end
   end

   // line buffer address and write data, one column per step
   always_comb begin
      mem_addr  = col_ff + COL_W'(step_ff) - COL_W'(2);
      mem_we    = 1'b0;
      mem_wdata = '0;
      if (state_ff == ST_WRITE) begin
         case (step_ff)
            2'd0: begin
               mem_we    = pos_ff.c_ge2;
               mem_wdata = {prv_win_ff[0], recent1_ff};
            end
            2'd1: begin
               mem_we    = pos_ff.last_col && pos_ff.c_ge1;
               mem_wdata = {prv_win_ff[1], recent0_ff};
            end
            default: begin
               mem_we    = pos_ff.last_col;
               mem_wdata = {prv_win_ff[2], pix_ff};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) line_mem[mem_addr] <= mem_wdata;
      rd_data_ff <= line_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         old_win_ff[rd_slot_ff] <= rd_data_ff[2*PIX_W-1:PIX_W];
         prv_win_ff[rd_slot_ff] <= rd_data_ff[PIX_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (pop_valid) state_in = ST_READ;
         ST_READ:   if (step_ff == 2'd2) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_SELECT;
         ST_SELECT: state_in = (pend_ff == '0) ? ST_WRITE : ST_DIV;
         ST_DIV:    state_in = ST_OUT;
         ST_OUT:    if (out_load) state_in = ST_SELECT;
         ST_WRITE:  if (step_ff == 2'd2) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         pend_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         recent0_ff   <= '0;
         recent1_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= (state_ff == ST_READ);
         if (state_ff == ST_IDLE && pop_valid) begin
            pend_ff <= new_mask;
            step_ff <= '0;
         end
         if (state_ff == ST_READ || state_ff == ST_WRITE)
            step_ff <= (step_ff == 2'd2) ? 2'd0 : step_ff + 2'd1;
         if (state_ff == ST_SELECT) pend_ff <= pend_ff & ~kind_bit;
         if (state_ff == ST_WRITE && step_ff == 2'd2) begin
            if (pos_ff.last_col) begin
               recent0_ff <= '0;
               recent1_ff <= '0;
            end else begin
               recent1_ff <= recent0_ff;
               recent0_ff <= pix_ff;
            end
         end
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rd_slot_ff <= step_ff;
      if (state_ff == ST_IDLE && pop_valid) begin
         pix_ff <= pop_pix;
         pos_ff <= pop_pos;
         col_ff <= pop_col;
      end
      if (state_ff == ST_SELECT) begin
         for (int ch = 0; ch < 3; ch++) sum_ff[ch] <= sum_calc[ch];
         cnt_ff       <= cnt_calc;
         run_end_ff   <= ((pend_ff & ~kind_bit) == '0);
         frame_end_ff <= (kind_sel == KIND_LAST_HERE);
      end
      if (state_ff == ST_DIV) begin
         for (int ch = 0; ch < 3; ch++)
            prod_ff[ch] <= PROD_W'(NUM_W'({sum_ff[ch], 1'b0}) + NUM_W'(cnt_ff))
                           * PROD_W'(recip(cnt_ff));
      end
      if (out_load) begin
         rsp_red_ff       <= prod_ff[0][RECIP_SHIFT +: 8];
         rsp_green_ff     <= prod_ff[1][RECIP_SHIFT +: 8];
         rsp_blue_ff      <= prod_ff[2][RECIP_SHIFT +: 8];
         rsp_run_end_ff   <= run_end_ff;
         rsp_frame_end_ff <= frame_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_red_ff;
   assign rsp_green_out = rsp_green_ff;
   assign rsp_blue_out  = rsp_blue_ff;
   assign rsp_run_end   = rsp_run_end_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result register overwritten while stalled");

   a_frame_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_frame_end_ff) |-> rsp_run_end_ff)
      else $error("frame end without run end");

   a_div_then_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |=> (state_ff == ST_OUT))
      else $error("divide step not followed by output step");

   a_write_only_in_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_WRITE && pend_ff == '0))
      else $error("line buffer written with results pending");

endmodule

`default_nettype wire

>>> dv/box_blur_checker.sv
// checker for the 3x3 box blur: predicts blurred pixels and compares the result channel
`default_nettype none

module box_blur_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [bbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bbc_pkg::CSR_DATA_W-1:0]  csr_data,
   input  wire logic                            req_valid,
   input  wire logic                            req_ready,
   input  wire logic [7:0]                      req_red,
   input  wire logic [7:0]                      req_green,
   input  wire logic [7:0]                      req_blue,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire logic [7:0]                      rsp_red_out,
   input  wire logic [7:0]                      rsp_green_out,
   input  wire logic [7:0]                      rsp_blue_out,
   input  wire logic                            rsp_run_end,
   input  wire logic                            rsp_frame_end,
   output int                                   pending,
   output int                                   failures
);
   timeunit 1ns;
   timeprecision 1ps;

   import bbc_pkg::*;

   localparam int LINE_DEPTH = 1024;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       run_end;
      logic       frame_end;
   } blur_result_type;

   blur_result_type blurred_q[$];

   logic [WIDTH_CFG_W-1:0]  width_reg;
   logic [HEIGHT_CFG_W-1:0] height_reg;
   rgb_type older_line[LINE_DEPTH];
   rgb_type prev_line[LINE_DEPTH];
   rgb_type recent[2];
   rgb_type cur_pix;
   int col_pos, row_pos, cur_col, cur_row, eff_w, eff_h;

   assign pending = blurred_q.size();

   function automatic rgb_type window_pixel(int rel, int col);
      if (col < 0 || col >= eff_w) return '0;
      if (rel == -2) return older_line[col];
      if (rel == -1) return prev_line[col];
      if (col == cur_col) return cur_pix;
      if (col == cur_col - 1) return recent[0];
      if (col == cur_col - 2) return recent[1];
      return '0;
   endfunction

   task automatic push_average(int orow, int ocol, logic fend);
      int sum_r, sum_g, sum_b, cnt, rr, cc, rel;
      rgb_type p;
      blur_result_type res;
      sum_r = 0; sum_g = 0; sum_b = 0; cnt = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            rr = orow + dr;
            cc = ocol + dc;
            rel = rr - cur_row;
            if (rr >= 0 && rr < eff_h && cc >= 0 && cc < eff_w && rel >= -2 && rel <= 0) begin
               p = window_pixel(rel, cc);
               sum_r += p.red;
               sum_g += p.green;
               sum_b += p.blue;
               cnt++;
            end
         end
      end
      res.red       = 8'((2 * sum_r + cnt) / (2 * cnt));
      res.green     = 8'((2 * sum_g + cnt) / (2 * cnt));
      res.blue      = 8'((2 * sum_b + cnt) / (2 * cnt));
      res.run_end   = 1'b0;
      res.frame_end = fend;
      blurred_q.push_back(res);
   endtask

   task automatic blur_pixel(rgb_type pix);
      int n, c, r;
      logic lastc, lastr;
      n = 0;
      eff_w = (width_reg < 1) ? 1 : (width_reg > LINE_DEPTH ? LINE_DEPTH : int'(width_reg));
      eff_h = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : int'(height_reg));
      if (col_pos >= eff_w) col_pos = eff_w - 1;
      if (row_pos >= eff_h) row_pos = eff_h - 1;
      c = col_pos;
      r = row_pos;
      cur_col = c;
      cur_row = r;
      cur_pix = pix;
      lastc = (c == eff_w - 1);
      lastr = (r == eff_h - 1);
      if (c >= 1) begin
         if (r >= 1) begin push_average(r - 1, c - 1, 1'b0); n++; end
         if (lastr) begin push_average(r, c - 1, 1'b0); n++; end
      end
      if (lastc) begin
         if (r >= 1) begin push_average(r - 1, c, 1'b0); n++; end
         if (lastr) begin push_average(r, c, 1'b1); n++; end
      end
      if (n > 0) blurred_q[$].run_end = 1'b1;
      // retire columns no later window of this row needs
      if (c >= 2) begin
         older_line[c-2] = prev_line[c-2];
         prev_line[c-2]  = recent[1];
      end
      if (lastc) begin
         if (c >= 1) begin
            older_line[c-1] = prev_line[c-1];
            prev_line[c-1]  = recent[0];
         end
         older_line[c] = prev_line[c];
         prev_line[c]  = pix;
      end
      recent[1] = recent[0];
      recent[0] = pix;
      if (lastc) begin
         col_pos = 0;
         recent[0] = '0;
         recent[1] = '0;
         row_pos = lastr ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   always @(posedge clock) begin
      blur_result_type want;
      if (reset) begin
         width_reg  = 11'd1024;
         height_reg = 13'd1024;
         col_pos = 0;
         row_pos = 0;
         recent[0] = '0;
         recent[1] = '0;
         for (int i = 0; i < LINE_DEPTH; i++) begin
            older_line[i] = '0;
            prev_line[i]  = '0;
         end
         blurred_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IMAGE_WIDTH) width_reg = csr_data[WIDTH_CFG_W-1:0];
            else if (csr_index == CSR_IMAGE_HEIGHT) height_reg = csr_data[HEIGHT_CFG_W-1:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (blurred_q.size() == 0) begin
               failures++;
               $display("%0t: unexpected result r=%0d g=%0d b=%0d", $realtime,
                        rsp_red_out, rsp_green_out, rsp_blue_out);
            end else begin
               want = blurred_q.pop_front();
               if (rsp_red_out !== want.red || rsp_green_out !== want.green ||
                   rsp_blue_out !== want.blue || rsp_run_end !== want.run_end ||
                   rsp_frame_end !== want.frame_end) begin
                  failures++;
                  $display("%0t: mismatch expected r=%0d g=%0d b=%0d run_end=%0b frame_end=%0b",
                           $realtime, want.red, want.green, want.blue, want.run_end,
                           want.frame_end);
                  $display("%0t:          actual   r=%0d g=%0d b=%0d run_end=%0b frame_end=%0b",
                           $realtime, rsp_red_out, rsp_green_out, rsp_blue_out, rsp_run_end,
                           rsp_frame_end);
               end
            end
         end
         if (req_valid && req_ready)
            blur_pixel(rgb_type'({req_blue, req_green, req_red}));
      end
   end

   initial failures = 0;

endmodule

`default_nettype wire

>>> dv/tb.sv
// testbench top for the 3x3 box blur: clock, reset, pixel stimulus and verdict
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bbc_pkg::*;

   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 3000;
   localparam int ITEM_TARGET  = 330;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_red = '0, req_green = '0, req_blue = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_red_out, rsp_green_out, rsp_blue_out;
   logic rsp_run_end, rsp_frame_end;
   int pending, failures;
   int pixels_sent = 0;
   int quiet_cycles = 0;
   logic steady = 1'b0;

   always #4 clock = ~clock;

   box_blur_3x3_edge_clipped_core DUT (.*);

   box_blur_checker u_checker (.*);

   always @(negedge clock)
      rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 34);

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, int value);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_size(int w, int h);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
   endtask

   // saturated bytes when extreme is set, else full range
   task automatic send_pixels(int count, bit extreme);
      for (int i = 0; i < count; i++) begin
         while (!steady && $urandom_range(99) < 34) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid <= 1'b1;
         req_red   <= extreme ? ($urandom_range(1) ? 8'hff : 8'h00) : 8'($urandom);
         req_green <= extreme ? ($urandom_range(1) ? 8'hff : 8'h00) : 8'($urandom);
         req_blue  <= extreme ? ($urandom_range(1) ? 8'hff : 8'h00) : 8'($urandom);
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         pixels_sent++;
         @(negedge clock);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      int w, h;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_size(1, 1);
      send_pixels(1, 1'b1);
      set_size(0, 0);
      send_pixels(1, 1'b0);
      set_size(3, 3);
      send_pixels(9, 1'b1);
      set_size(2, 4);
      send_pixels(8, 1'b0);
      // width lowered mid-row, column saturates to the last one
      set_size(6, 5);
      send_pixels(17, 1'b0);
      set_size(4, 7);
      send_pixels(17, 1'b0);
      // height lowered mid-frame, row saturates to the last one
      set_size(3, 6);
      send_pixels(12, 1'b1);
      write_reg(CSR_IMAGE_HEIGHT, 2);
      send_pixels(3, 1'b0);
      // out-of-range width, narrowed mid-row to close the frame
      steady = 1'b1;
      set_size(8191, 1);
      send_pixels(10, 1'b0);
      write_reg(CSR_IMAGE_WIDTH, 11);
      send_pixels(1, 1'b0);
      // out-of-range height, shortened mid-frame to close it
      set_size(1, 8191);
      send_pixels(6, 1'b0);
      write_reg(CSR_IMAGE_HEIGHT, 7);
      send_pixels(1, 1'b1);
      steady = 1'b0;

      while (pixels_sent < ITEM_TARGET) begin
         steady = (pixels_sent >= 100 && pixels_sent < 180);
         w = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         h = $urandom_range(1, 6);
         set_size(w, h);
         send_pixels(w * h, $urandom_range(3) == 0);
      end
      steady = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
